// ===== rtl/core/pet_pkg.sv =====
// Package for the Prewitt edge threshold block: types, codes and constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pet_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int PIX_W    = 8;
    localparam int CFG_W    = 9;
    localparam int NUM_TAPS = 8;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_IMAGE_WIDTH    = 2'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT   = 2'd1;
    localparam t_reg_idx REG_EDGE_THRESHOLD = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 9'd256;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 9'd256;
    localparam logic [PIX_W-1:0] RST_EDGE_THRESHOLD = 8'd10;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;
    localparam logic [PIX_W-1:0] SUM_MAX  = 8'd255;

    // reciprocal of 3 for magnitudes below 2048
    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    typedef logic [2:0] t_tap;
    localparam t_tap TAP_NW = 3'd0;
    localparam t_tap TAP_N  = 3'd1;
    localparam t_tap TAP_NE = 3'd2;
    localparam t_tap TAP_W  = 3'd3;
    localparam t_tap TAP_E  = 3'd4;
    localparam t_tap TAP_SW = 3'd5;
    localparam t_tap TAP_S  = 3'd6;
    localparam t_tap TAP_SE = 3'd7;

    typedef logic [NUM_TAPS-1:0][PIX_W-1:0] t_taps;

    typedef struct packed {
        logic [PIX_W-1:0] gradient_sum;
        logic [PIX_W-1:0] edge_pixel;
    } t_grad_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_POST
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/pet_frame_mem.sv =====
// Single-port frame store with registered read.
// Depends on pet_pkg for the pixel width.
`timescale 1ns / 1ps
`default_nettype none

module pet_frame_mem
    import pet_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [PIX_W-1:0] i_wdata,
    output logic      [PIX_W-1:0] o_rdata
);

    logic [PIX_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/pet_grad.sv =====
// Gradient combiner: halved differences, 3-tap average, abs sum and threshold.
// Depends on pet_pkg for tap order, constants and the result struct.
`timescale 1ns / 1ps
`default_nettype none

module pet_grad
    import pet_pkg::*;
(
    input  wire t_taps            i_taps,
    input  wire logic [PIX_W-1:0] i_threshold,
    output t_grad_res             o_res
);

    function automatic logic signed [7:0] half_diff(input logic [PIX_W-1:0] a,
                                                    input logic [PIX_W-1:0] b);
        logic signed [8:0] d;
        logic signed [9:0] t;
        begin
            d = $signed({1'b0, a}) - $signed({1'b0, b});
            t = $signed({d[8], d}) + $signed({9'd0, d[8]});
            return t[8:1];
        end
    endfunction

    function automatic logic [7:0] abs_div3(input logic signed [7:0] x0,
                                            input logic signed [7:0] x1,
                                            input logic signed [7:0] x2);
        logic signed [9:0] s;
        logic        [8:0] mag;
        logic        [18:0] prod;
        begin
            s    = 10'(x0) + 10'(x1) + 10'(x2);
            mag  = s[9] ? 9'(-s) : s[8:0];
            prod = 19'(mag) * 19'(DIV3_MUL);
            return prod[DIV3_SHIFT +: 8];
        end
    endfunction

    logic [7:0] gx_abs;
    logic [7:0] gy_abs;
    logic [8:0] sum;
    logic [7:0] sum_clip;

    always_comb begin
        gx_abs = abs_div3(half_diff(i_taps[TAP_NW], i_taps[TAP_NE]),
                          half_diff(i_taps[TAP_W],  i_taps[TAP_E]),
                          half_diff(i_taps[TAP_SW], i_taps[TAP_SE]));
        gy_abs = abs_div3(half_diff(i_taps[TAP_NW], i_taps[TAP_SW]),
                          half_diff(i_taps[TAP_N],  i_taps[TAP_S]),
                          half_diff(i_taps[TAP_NE], i_taps[TAP_SE]));
        sum      = 9'(gx_abs) + 9'(gy_abs);
        sum_clip = sum[8] ? SUM_MAX : sum[7:0];
        o_res.gradient_sum = sum_clip;
        o_res.edge_pixel   = (sum_clip > i_threshold) ? EDGE_ON : EDGE_OFF;
    end

endmodule

`default_nettype wire

// ===== rtl/core/prewitt_edge_threshold.sv =====
// Prewitt edge threshold: a write word goes from idle straight to the post state; a query
// does eight reads through the single frame-store port, waits for the last read return and
// combines. One word is in work at a time: a new word is taken only in idle, and post waits
// for a free output slot. The next word is accepted while a finished result waits.
// Reset (synchronous, active low) clears control and restores register defaults;
// the frame store is not cleared and holds undefined data until written.
`timescale 1ns / 1ps
`default_nettype none

module prewitt_edge_threshold
    import pet_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  wire logic [23:0]      i_s_axis_tdata,  // row, col, pixel_value
    input  wire logic             i_s_axis_tuser,  // req_type
    output logic                  o_m_axis_tvalid,
    input  wire logic             i_m_axis_tready,
    output logic      [15:0]      o_m_axis_tdata,  // edge_pixel, gradient_sum
    input  wire logic             i_cfg_we,
    input  wire t_reg_idx         i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int MW    = (RW > CW) ? RW : CW;
    localparam int SW    = ((MW > CFG_W) ? MW : CFG_W) + 1;

    t_state            r_state, n_state;
    logic [2:0]        r_cnt, n_cnt;
    logic              r_is_query, n_is_query;
    logic [RW-1:0]     r_rm, r_r, r_rp;
    logic [CW-1:0]     r_cm, r_c, r_cp;
    logic              r_rd_valid;
    t_tap              r_rd_idx;
    t_taps             r_taps;
    logic              r_out_valid;
    t_grad_res         r_out;
    logic [CFG_W-1:0]  r_width, r_height;
    logic [PIX_W-1:0]  r_thr;

    logic              in_acc, out_load, coord_load;
    logic [SW-1:0]     h_eff, w_eff, rlast_w, clast_w, in_row_ext, in_col_ext;
    logic [RW-1:0]     rlast, q_row, q_rm, q_rp, sel_row;
    logic [CW-1:0]     clast, q_col, q_cm, q_cp, sel_col;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [PIX_W-1:0]  mem_rdata;
    t_grad_res         grad_res;

    always_comb begin
        if (r_height == '0) begin
            h_eff = SW'(1);
        end else if (SW'(r_height) > SW'(MAX_HEIGHT)) begin
            h_eff = SW'(MAX_HEIGHT);
        end else begin
            h_eff = SW'(r_height);
        end
        if (r_width == '0) begin
            w_eff = SW'(1);
        end else if (SW'(r_width) > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(r_width);
        end
        rlast_w    = h_eff - SW'(1);
        clast_w    = w_eff - SW'(1);
        rlast      = rlast_w[RW-1:0];
        clast      = clast_w[CW-1:0];
        in_row_ext = SW'(i_s_axis_tdata[7:0]);
        in_col_ext = SW'(i_s_axis_tdata[15:8]);
        q_row = (in_row_ext > rlast_w) ? rlast : in_row_ext[RW-1:0];
        q_col = (in_col_ext > clast_w) ? clast : in_col_ext[CW-1:0];
        q_rm  = (q_row == '0) ? '0 : q_row - RW'(1);
        q_rp  = (q_row == rlast) ? rlast : q_row + RW'(1);
        q_cm  = (q_col == '0) ? '0 : q_col - CW'(1);
        q_cp  = (q_col == clast) ? clast : q_col + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cnt      <= '0;
            r_is_query <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_is_query <= n_is_query;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_is_query      = r_is_query;
        o_s_axis_tready = 1'b0;
        in_acc          = 1'b0;
        out_load        = 1'b0;
        coord_load      = 1'b0;
        mem_we          = 1'b0;
        sel_row         = r_r;
        sel_col         = r_c;
        unique case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                in_acc          = i_s_axis_tvalid;
                sel_row         = in_row_ext[RW-1:0];
                sel_col         = in_col_ext[CW-1:0];
                if (in_acc) begin
                    n_is_query = (i_s_axis_tuser == REQ_QUERY);
                    n_cnt      = '0;
                    if (i_s_axis_tuser == REQ_QUERY) begin
                        coord_load = 1'b1;
                        n_state    = S_READ;
                    end else begin
                        mem_we  = (in_row_ext < SW'(MAX_HEIGHT)) &&
                                  (in_col_ext < SW'(MAX_WIDTH));
                        n_state = S_POST;
                    end
                end
            end
            S_READ: begin
                case (r_cnt) inside
                    TAP_NW, TAP_N, TAP_NE: sel_row = r_rm;
                    TAP_W, TAP_E:          sel_row = r_r;
                    default:               sel_row = r_rp;
                endcase
                case (r_cnt) inside
                    TAP_NW, TAP_W, TAP_SW: sel_col = r_cm;
                    TAP_N, TAP_S:          sel_col = r_c;
                    default:               sel_col = r_cp;
                endcase
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == TAP_SE) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_POST;
            end
            S_POST: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        mem_addr = AW'(32'(sel_row) * 32'(MAX_WIDTH)) + AW'(sel_col);
    end

    always_ff @(posedge i_clk) begin
        if (coord_load) begin
            r_rm <= q_rm;
            r_r  <= q_row;
            r_rp <= q_rp;
            r_cm <= q_cm;
            r_c  <= q_col;
            r_cp <= q_cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= (r_state == S_READ);
        end
        r_rd_idx <= r_cnt;
        if (r_rd_valid) begin
            r_taps[r_rd_idx] <= mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out <= r_is_query ? grad_res : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_thr    <= RST_EDGE_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:    r_width  <= i_cfg_wdata;
                REG_IMAGE_HEIGHT:   r_height <= i_cfg_wdata;
                REG_EDGE_THRESHOLD: r_thr    <= i_cfg_wdata[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    pet_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_s_axis_tdata[23:16]),
        .o_rdata (mem_rdata)
    );

    pet_grad u_grad (
        .i_taps      (r_taps),
        .i_threshold (r_thr),
        .o_res       (grad_res)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.gradient_sum, r_out.edge_pixel};

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE))
        else $error("frame store written outside idle");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_cnt == TAP_SE) |=> (r_state == S_WAIT))
        else $error("read sweep did not end after last tap");

    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POST && !r_out_valid) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not posted into free output slot");

    a_edge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[7:0] == EDGE_OFF ||
                             o_m_axis_tdata[7:0] == EDGE_ON))
        else $error("edge result neither on nor off");

    a_edge_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[7:0] == EDGE_ON) |->
            (o_m_axis_tdata[15:8] > r_thr))
        else $error("edge flagged at or below threshold");

endmodule

`default_nettype wire

// ===== dv/prewitt_edge_threshold_tb.sv =====
// Testbench for prewitt_edge_threshold: pixel writes and edge queries in, edge words out.
// Holds its own frame copy and gradient predictor; needs pet_pkg and the block's RTL.
`timescale 1ns / 1ps

module prewitt_edge_threshold_tb;
    import pet_pkg::*;

    localparam int       STORE_W   = DEF_MAX_WIDTH;
    localparam int       IDLE_MAX  = 2000;
    localparam int       N_PHASES  = 8;
    localparam int       PHASE_LEN = 125;
    localparam t_reg_idx REG_UNUSED = 2'd3;
    localparam t_grad_res WRITE_ACK = '{gradient_sum: 8'd0, edge_pixel: EDGE_OFF};

    typedef enum logic [1:0] {
        ACT_WRITE,
        ACT_QUERY,
        ACT_CONFIG
    } t_action;

    typedef struct packed {
        t_action    act;
        t_reg_idx   idx;
        logic [7:0] row;
        logic [7:0] col;
        logic [8:0] val;
        logic       typed;
        t_grad_res  res;
    } t_step;

    logic             i_clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_valid = 1'b0;
    logic [23:0]      s_tdata = '0;
    logic             s_tuser = REQ_WRITE;
    logic             m_ready = 1'b0;
    logic             cfg_we = 1'b0;
    t_reg_idx         cfg_idx = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             o_s_axis_tready;
    logic             o_m_axis_tvalid;
    logic [15:0]      o_m_axis_tdata;

    logic [7:0] frame_px [STORE_W * DEF_MAX_HEIGHT];
    bit         written  [STORE_W * DEF_MAX_HEIGHT];
    logic [8:0] img_width  = RST_IMAGE_WIDTH;
    logic [8:0] img_height = RST_IMAGE_HEIGHT;
    logic [7:0] edge_thr   = RST_EDGE_THRESHOLD;

    t_grad_res edge_words_due [$];
    t_step     steps [31];
    int        items_sent = 0;
    int        n_bad = 0;
    int        idle_cycles = 0;
    bit        bursts_on = 1'b1;

    always #5 i_clk = ~i_clk;

    prewitt_edge_threshold dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    function automatic int clip_idx(input int v, input int last);
        if (v < 0) return 0;
        if (v > last) return last;
        return v;
    endfunction

    function automatic int active_size(input logic [8:0] v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    function automatic int pel(input int r, input int c, input int rl, input int cl);
        return int'(frame_px[clip_idx(r, rl) * STORE_W + clip_idx(c, cl)]);
    endfunction

    function automatic t_grad_res edge_response(input logic [7:0] qr, input logic [7:0] qc);
        int        rl, cl, r, c, k, rr, cc, gx, gy, mag;
        t_grad_res res;
        rl = active_size(img_height, DEF_MAX_HEIGHT) - 1;
        cl = active_size(img_width, DEF_MAX_WIDTH) - 1;
        r  = clip_idx(int'(qr), rl);
        c  = clip_idx(int'(qc), cl);
        gx = 0;
        gy = 0;
        for (k = -1; k <= 1; k++) begin
            rr = clip_idx(r + k, rl);
            cc = clip_idx(c + k, cl);
            gx = gx + (pel(rr, c - 1, rl, cl) - pel(rr, c + 1, rl, cl)) / 2;
            gy = gy + (pel(r - 1, cc, rl, cl) - pel(r + 1, cc, rl, cl)) / 2;
        end
        gx = gx / 3;
        gy = gy / 3;
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        mag = gx + gy;
        if (mag > 255) mag = 255;
        res.gradient_sum = 8'(mag);
        res.edge_pixel   = (mag > int'(edge_thr)) ? EDGE_ON : EDGE_OFF;
        return res;
    endfunction

    function automatic logic [8:0] pick_size();
        case ($urandom_range(0, 7))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd256;
            3: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(2, 12));
        endcase
    endfunction

    // mostly near a base level so sums land around the threshold
    function automatic logic [7:0] pick_pel(input int base);
        int n;
        if ($urandom_range(0, 2) == 0) return 8'($urandom);
        n = base + int'($urandom_range(0, 40)) - 20;
        return 8'(clip_idx(n, 255));
    endfunction

    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(negedge i_clk); while (edge_words_due.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [8:0] val);
        wait_results_done();
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:    img_width  = val;
            REG_IMAGE_HEIGHT:   img_height = val;
            REG_EDGE_THRESHOLD: edge_thr   = val[7:0];
            default: ;
        endcase
    endtask

    task automatic send_word(input logic req, input logic [7:0] r, input logic [7:0] c,
                             input logic [7:0] v, input logic typed, input t_grad_res typed_res);
        t_grad_res want;
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {v, c, r};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (req == REQ_WRITE) begin
            frame_px[{r, c}] = v;
            written[{r, c}]  = 1'b1;
            want = WRITE_ACK;
        end else begin
            want = edge_response(r, c);
        end
        if (typed) want = typed_res;
        edge_words_due.push_back(want);
        items_sent++;
    endtask

    always @(posedge i_clk) begin : check_out
        t_grad_res got, want;
        if (rst_n && o_m_axis_tvalid && m_ready) begin
            got = o_m_axis_tdata;
            if (edge_words_due.size() == 0) begin
                $error("edge word with nothing outstanding: %h", got);
                n_bad++;
            end else begin
                want = edge_words_due.pop_front();
                if (got.edge_pixel !== want.edge_pixel) begin
                    $error("edge_pixel: expected %0d, got %0d", want.edge_pixel, got.edge_pixel);
                    n_bad++;
                end
                if (got.gradient_sum !== want.gradient_sum) begin
                    $error("gradient_sum: expected %0d, got %0d",
                           want.gradient_sum, got.gradient_sum);
                    n_bad++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (bursts_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            m_ready <= 1'b1;
        end
    end

    initial begin
        int         phase, roll, rl, cl, r, c, dr, dc, pr, pc, base, goal;
        logic [7:0] qr, qc, lr, lc, thr;
        bit         have_last;

        steps = '{
            '{ACT_WRITE,  REG_UNUSED,         8'd0,   8'd0,   9'd0,   1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd0,   8'd1,   9'd255, 1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd1,   8'd0,   9'd0,   1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd1,   8'd1,   9'd255, 1'b1, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd0,   8'd0,   9'd0,   1'b1, '{8'd127, EDGE_ON}},
            '{ACT_CONFIG, REG_EDGE_THRESHOLD, 8'd0,   8'd0,   9'd255, 1'b0, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd0,   8'd0,   9'd0,   1'b1, '{8'd127, EDGE_OFF}},
            '{ACT_CONFIG, REG_EDGE_THRESHOLD, 8'd0,   8'd0,   9'd0,   1'b0, WRITE_ACK},
            '{ACT_CONFIG, REG_IMAGE_WIDTH,    8'd0,   8'd0,   9'd0,   1'b0, WRITE_ACK},
            '{ACT_CONFIG, REG_IMAGE_HEIGHT,   8'd0,   8'd0,   9'd1,   1'b0, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd200, 8'd200, 9'd0,   1'b1, '{8'd0, EDGE_OFF}},
            '{ACT_CONFIG, REG_IMAGE_WIDTH,    8'd0,   8'd0,   9'd511, 1'b0, WRITE_ACK},
            '{ACT_CONFIG, REG_IMAGE_HEIGHT,   8'd0,   8'd0,   9'd511, 1'b0, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd254, 8'd254, 9'd255, 1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd254, 8'd255, 9'd0,   1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd255, 8'd254, 9'd255, 1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd255, 8'd255, 9'd0,   1'b1, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd255, 8'd255, 9'd0,   1'b1, '{8'd127, EDGE_ON}},
            '{ACT_CONFIG, REG_UNUSED,         8'd0,   8'd0,   9'd511, 1'b0, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd255, 8'd255, 9'd0,   1'b0, WRITE_ACK},
            '{ACT_CONFIG, REG_EDGE_THRESHOLD, 8'd0,   8'd0,   9'd10,  1'b0, WRITE_ACK},
            '{ACT_CONFIG, REG_IMAGE_WIDTH,    8'd0,   8'd0,   9'd3,   1'b0, WRITE_ACK},
            '{ACT_CONFIG, REG_IMAGE_HEIGHT,   8'd0,   8'd0,   9'd3,   1'b0, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd2,   8'd2,   9'd128, 1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd0,   8'd2,   9'd200, 1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd2,   8'd0,   9'd50,  1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd1,   8'd2,   9'd17,  1'b1, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd2,   8'd1,   9'd90,  1'b1, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd1,   8'd1,   9'd0,   1'b0, WRITE_ACK},
            '{ACT_QUERY,  REG_UNUSED,         8'd9,   8'd200, 9'd0,   1'b0, WRITE_ACK},
            '{ACT_WRITE,  REG_UNUSED,         8'd100, 8'd100, 9'd77,  1'b1, WRITE_ACK}
        };

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (steps[i]) begin
            case (steps[i].act)
                ACT_CONFIG: write_reg(steps[i].idx, steps[i].val);
                ACT_WRITE:  send_word(REQ_WRITE, steps[i].row, steps[i].col, steps[i].val[7:0],
                                      steps[i].typed, steps[i].res);
                default:    send_word(REQ_QUERY, steps[i].row, steps[i].col, 8'hA5,
                                      steps[i].typed, steps[i].res);
            endcase
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            write_reg(REG_IMAGE_WIDTH, (phase == 0) ? 9'd256 : pick_size());
            write_reg(REG_IMAGE_HEIGHT, (phase == 0) ? 9'd256 : pick_size());
            case (phase % 4)
                1: thr = 8'd0;
                2: thr = 8'd255;
                default: thr = 8'($urandom_range(0, 60));
            endcase
            write_reg(REG_EDGE_THRESHOLD, {1'b0, thr});
            rl = active_size(img_height, DEF_MAX_HEIGHT) - 1;
            cl = active_size(img_width, DEF_MAX_WIDTH) - 1;
            have_last = 1'b0;
            goal = items_sent + PHASE_LEN;
            while (items_sent < goal) begin
                bursts_on = (phase < N_PHASES - 1) || (items_sent < goal - 100);
                roll = $urandom_range(0, 9);
                if (roll == 9 && have_last) begin
                    send_word(REQ_QUERY, lr, lc, 8'($urandom), 1'b0, WRITE_ACK);
                end else if (roll >= 7) begin
                    qr = 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, rl)
                                                        : $urandom_range(0, 255));
                    qc = 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, cl)
                                                        : $urandom_range(0, 255));
                    send_word(REQ_WRITE, qr, qc, pick_pel($urandom_range(0, 255)),
                              1'b0, WRITE_ACK);
                end else begin
                    qr = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, rl));
                    qc = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, cl));
                    r = clip_idx(int'(qr), rl);
                    c = clip_idx(int'(qc), cl);
                    base = $urandom_range(0, 255);
                    // fill the clamped neighborhood, then query
                    for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                            pr = clip_idx(r + dr, rl);
                            pc = clip_idx(c + dc, cl);
                            if (!written[pr * STORE_W + pc] || $urandom_range(0, 3) == 0)
                                send_word(REQ_WRITE, 8'(pr), 8'(pc), pick_pel(base),
                                          1'b0, WRITE_ACK);
                        end
                    end
                    send_word(REQ_QUERY, qr, qc, 8'($urandom), 1'b0, WRITE_ACK);
                    lr = qr;
                    lc = qc;
                    have_last = 1'b1;
                end
            end
        end

        bursts_on = 1'b0;
        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (n_bad == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
